### hw/rtl/fpdf_pkg.sv
`default_nettype none

package fpdf_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // register word index on the apb port
    localparam logic REG_DIGIT_COUNT     = 1'b0;
    localparam logic REG_FRACTION_DIGITS = 1'b1;

    localparam int unsigned MAX_DIGITS = 5;
    localparam int unsigned BIN_W      = 16;
    localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
    localparam int unsigned WORK_W     = BCD_W + BIN_W;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DD_STAGES  = BIN_W / STEPS_PER_STAGE;

    // ascii codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_POINT = 8'h2e;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // field limits by digit count; for codes above five the settings check rejects the value first
    localparam logic [16:0] POW_TEN [8] = '{
        17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000,
        17'd100000, 17'h1ffff, 17'h1ffff
    };

    // bcd digits in the upper bits, binary bits still to go in the lower
    typedef logic [WORK_W-1:0] work_t;

    typedef struct packed {
        work_t   work;
        status_t status;
    } stage_t;

    // one shift-add-3 step of the double dabble conversion
    function automatic work_t dd_step(input work_t x);
        work_t y;
        y = x;
        for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            if (y[BIN_W + 4*i +: 4] >= 4'd5) begin
                y[BIN_W + 4*i +: 4] = y[BIN_W + 4*i +: 4] + 4'd3;
            end
        end
        return {y[WORK_W-2:0], 1'b0};
    endfunction

    // the steps handled by one pipeline stage
    function automatic work_t dd_stage(input work_t x);
        work_t y;
        y = x;
        for (int s = 0; s < int'(STEPS_PER_STAGE); s++) begin
            y = dd_step(y);
        end
        return y;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fixed_point_decimal_formatter_unit.sv
// path: a value passes pipeline stage 0, the dabble stages, the serialiser registers and the output register
// throughput: one character beat per cycle while m_tready holds; a value takes digit_count beats, one more
//   when fraction_digits is not zero, and a single beat when rejected or overflowing
// the input side is set by the character serialiser: it takes the next value as the last beat of the one before loads
// reset: synchronous active-low aresetn empties the pipeline, digit_count 5, fraction_digits 1
`default_nettype none

module fixed_point_decimal_formatter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] value
    // character stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] character
    output logic             m_tlast,
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned NSTG = fpdf_pkg::DD_STAGES + 1;

    // configuration registers
    logic [2:0] digit_count_reg;
    logic [2:0] fraction_digits_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg     <= 3'd5;
            fraction_digits_reg <= 3'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == fpdf_pkg::REG_DIGIT_COUNT) begin
                digit_count_reg <= pwdata[2:0];
            end else begin
                fraction_digits_reg <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == fpdf_pkg::REG_FRACTION_DIGITS) ?
                    {29'd0, fraction_digits_reg} : {29'd0, digit_count_reg};

    // settings check and field overflow at the input
    logic              cfg_bad;
    logic              val_ovf;
    fpdf_pkg::status_t in_status;

    assign cfg_bad = (digit_count_reg < 3'd2) || (digit_count_reg > 3'd5) ||
                     (fraction_digits_reg > 3'd4) ||
                     ({1'b0, digit_count_reg} < ({1'b0, fraction_digits_reg} + 4'd2));
    assign val_ovf = {1'b0, s_tdata} >= fpdf_pkg::POW_TEN[digit_count_reg];

    always_comb begin
        if (cfg_bad) begin
            in_status = fpdf_pkg::ST_REJECT;
        end else if (val_ovf) begin
            in_status = fpdf_pkg::ST_OVERFLOW;
        end else begin
            in_status = fpdf_pkg::ST_OK;
        end
    end

    // conversion pipeline: stage 0 captures, the rest run the dabble steps
    fpdf_pkg::stage_t stg_reg  [NSTG];
    fpdf_pkg::stage_t stg_next [NSTG];
    logic             stg_vld_reg [NSTG];
    logic             stg_rdy     [NSTG+1];
    logic             ser_free;

    always_comb begin
        stg_rdy[NSTG] = ser_free;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_rdy[k] = !stg_vld_reg[k] || stg_rdy[k+1];
        end
    end

    assign s_tready = stg_rdy[0];

    always_comb begin
        stg_next[0].work   = {{fpdf_pkg::BCD_W{1'b0}}, s_tdata};
        stg_next[0].status = in_status;
        for (int k = 1; k < NSTG; k++) begin
            stg_next[k].work   = fpdf_pkg::dd_stage(stg_reg[k-1].work);
            stg_next[k].status = stg_reg[k-1].status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg[0] <= 1'b0;
        end else if (stg_rdy[0]) begin
            stg_vld_reg[0] <= s_tvalid;
        end
        if (stg_rdy[0]) begin
            stg_reg[0] <= stg_next[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (!aresetn) begin
                stg_vld_reg[k] <= 1'b0;
            end else if (stg_rdy[k]) begin
                stg_vld_reg[k] <= stg_vld_reg[k-1];
            end
            if (stg_rdy[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // output register state
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg,  m_tdata_next;
    logic        m_tlast_reg,  m_tlast_next;
    logic [1:0]  m_tuser_reg,  m_tuser_next;

    // character serialiser
    logic                ser_busy_reg,   ser_busy_next;
    logic [4:0][3:0]     ser_digits_reg, ser_digits_next;
    fpdf_pkg::status_t   ser_status_reg, ser_status_next;
    logic [2:0]          ser_p_reg,      ser_p_next;
    logic                ser_dot_reg,    ser_dot_next;
    logic                ser_shown_reg,  ser_shown_next;

    logic       out_load;
    logic       ser_adv;
    logic [3:0] cur_digit;
    logic       shown_eff;
    logic [7:0] cur_char;
    logic       cur_last;

    assign m_tvalid  = m_tvalid_reg;
    assign out_load  = !m_tvalid_reg || m_tready;
    assign ser_adv   = ser_busy_reg && out_load;
    assign ser_free  = !ser_busy_reg || (out_load && cur_last);
    assign cur_digit = ser_digits_reg[ser_p_reg];
    assign shown_eff = ser_shown_reg || (cur_digit != 4'd0) ||
                       (ser_p_reg <= fraction_digits_reg);

    // character at the current position
    always_comb begin
        if (ser_status_reg != fpdf_pkg::ST_OK) begin
            cur_char = fpdf_pkg::CHR_NUL;
            cur_last = 1'b1;
        end else if (ser_dot_reg) begin
            cur_char = fpdf_pkg::CHR_POINT;
            cur_last = 1'b0;
        end else begin
            cur_char = shown_eff ? (fpdf_pkg::CHR_ZERO | {4'd0, cur_digit})
                                 : fpdf_pkg::CHR_SPACE;
            cur_last = (ser_p_reg == 3'd0);
        end
    end

    // walk down the digit powers, inserting the point after the units digit when fraction_digits is not zero
    always_comb begin
        ser_busy_next   = ser_busy_reg;
        ser_digits_next = ser_digits_reg;
        ser_status_next = ser_status_reg;
        ser_p_next      = ser_p_reg;
        ser_dot_next    = ser_dot_reg;
        ser_shown_next  = ser_shown_reg;
        if (ser_adv) begin
            if (cur_last) begin
                ser_busy_next = 1'b0;
            end else if (ser_dot_reg) begin
                ser_dot_next = 1'b0;
                ser_p_next   = ser_p_reg - 3'd1;
            end else begin
                ser_shown_next = shown_eff;
                if ((ser_p_reg == fraction_digits_reg) && (fraction_digits_reg != 3'd0)) begin
                    ser_dot_next = 1'b1;
                end else begin
                    ser_p_next = ser_p_reg - 3'd1;
                end
            end
        end
        if (ser_free && stg_vld_reg[NSTG-1]) begin
            ser_busy_next   = 1'b1;
            ser_digits_next = stg_reg[NSTG-1].work[fpdf_pkg::WORK_W-1:fpdf_pkg::BIN_W];
            ser_status_next = stg_reg[NSTG-1].status;
            ser_p_next      = digit_count_reg - 3'd1;
            ser_dot_next    = 1'b0;
            ser_shown_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
        end else begin
            ser_busy_reg <= ser_busy_next;
        end
        ser_digits_reg <= ser_digits_next;
        ser_status_reg <= ser_status_next;
        ser_p_reg      <= ser_p_next;
        ser_dot_reg    <= ser_dot_next;
        ser_shown_reg  <= ser_shown_next;
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next = ser_busy_reg;
            m_tdata_next  = cur_char;
            m_tlast_next  = cur_last;
            m_tuser_next  = ser_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tuser = m_tuser_reg;

    // checks
    a_err_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != fpdf_pkg::ST_OK) |-> m_tlast && (m_tdata == fpdf_pkg::CHR_NUL))
        else $error("reject or overflow beat is not a single null beat");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == fpdf_pkg::ST_OK) || (m_tuser == fpdf_pkg::ST_REJECT) ||
                     (m_tuser == fpdf_pkg::ST_OVERFLOW))
        else $error("unknown status on output");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_busy_reg && (ser_status_reg == fpdf_pkg::ST_OK) |-> ser_p_reg <= 3'd4)
        else $error("serialiser position beyond the digit field");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> stg_vld_reg[0] && ser_busy_reg)
        else $error("input stalled with room in the pipeline");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_busy_reg && !out_load |=> ser_busy_reg && $stable(ser_p_reg))
        else $error("serialiser moved while output stalled");

endmodule

`default_nettype wire
